// ===== design/nfa_chk_pkg.sv =====
// Shared constants and codes for the table-driven automaton event checker.
package nfa_chk_pkg;

    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 16;
    localparam int KEY_BITS_DEF = 8;

    // Width of the row mask ports and of the row and column count compares
    localparam int MASK_W  = 32;
    localparam int CNT_W   = 7;
    localparam int FIELD_W = 16;

    localparam logic [2:0] OP_EVENT    = 3'd0;
    localparam logic [2:0] OP_LOAD_KEY = 3'd1;
    localparam logic [2:0] OP_LOAD_CELL = 3'd2;
    localparam logic [2:0] OP_LOAD_END = 3'd3;
    localparam logic [2:0] OP_RESTORE  = 3'd4;

    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [1:0] CFG_COL_COUNT = 2'd2;

    localparam logic [5:0] ROW_COUNT_RST = 6'd32;
    localparam logic [4:0] COL_COUNT_RST = 5'd16;

endpackage

// ===== design/table_driven_nfa_event_checker_core.sv =====
// Loads, restores and unused opcodes give their result in the cycle after the transfer.
// Events out of scope give their result from the key-compare state; in-scope events go on
// to the row-scan state, one cell-memory row read per cycle, busy high throughout.
// Loads keep busy low, so one can be taken every cycle; results cannot be stalled.
// Reset: only row 0 active, no end rows, no column keys valid, mode 0, 32 rows, 16 columns.
// The cell memory is not cleared; every cell must be loaded before an event reads it.
module table_driven_nfa_event_checker_core #(
    parameter int MAX_ROWS = nfa_chk_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = nfa_chk_pkg::MAX_COLS_DEF,
    parameter int KEY_BITS = nfa_chk_pkg::KEY_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [7:0]  ev_type,
    input  logic [7:0]  ev_message,
    input  logic [7:0]  ev_origin,
    input  logic [4:0]  row_index,
    input  logic [3:0]  col_index,
    input  logic [31:0] row_mask,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    output logic        done,
    output logic        in_scope,
    output logic        violated,
    output logic        error_matched,
    output logic        holds,
    output logic [31:0] active_set
);

    localparam int RIW   = $clog2(MAX_ROWS);
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KEY_W = 3 * KEY_BITS;
    localparam int MW    = nfa_chk_pkg::MASK_W;
    localparam int CW    = nfa_chk_pkg::CNT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_SCAN} state_t;

    state_t state_reg;

    // Configuration registers
    logic       mode_reg;
    logic [5:0] row_count_reg;
    logic [4:0] col_count_reg;

    // Automaton state
    logic [MAX_ROWS-1:0] active_reg;
    logic [MAX_ROWS-1:0] end_reg;
    logic [KEY_W-1:0]    col_key_reg [MAX_COLS];
    logic [MAX_COLS-1:0] key_valid_reg;
    logic [MAX_COLS-1:0][MAX_ROWS-1:0] cell_mem [MAX_ROWS];

    // Event step
    logic [KEY_W-1:0]    key_reg;
    logic [MAX_COLS-1:0] hit_reg;
    logic [CW-1:0]       rd_row_reg;
    logic                pend_reg;
    logic [RIW-1:0]      pend_row_reg;
    logic [MAX_COLS-1:0][MAX_ROWS-1:0] rd_data_reg;
    logic [MAX_ROWS-1:0] reached_reg;
    logic [MAX_ROWS-1:0] kept_reg;
    logic                viol_reg;

    logic [CW-1:0]       rows_used;
    logic [CW-1:0]       cols_used;
    logic [MAX_ROWS-1:0] used_mask;
    logic [MAX_ROWS-1:0] mask_rows;
    logic [KEY_W-1:0]    in_key;
    logic [MAX_COLS-1:0] hit_now;
    logic                accept;
    logic                rd_en;
    logic                scan_end;
    logic [MAX_ROWS-1:0] load_active;
    logic [MAX_ROWS-1:0] load_end;
    logic [MAX_ROWS-1:0] row_reached;
    logic                row_moved;
    logic                row_empty;
    logic                row_act;
    logic [MAX_ROWS-1:0] fin_active;
    logic                fin_ematch;
    logic                fin_viol;
    logic [nfa_chk_pkg::FIELD_W-1:0] type_ext;
    logic [nfa_chk_pkg::FIELD_W-1:0] msg_ext;
    logic [nfa_chk_pkg::FIELD_W-1:0] org_ext;
    logic [MAX_ROWS+MW-1:0] mask_ext;

    function automatic logic [MW-1:0] to_port(input logic [MAX_ROWS-1:0] v);
        logic [MAX_ROWS+MW-1:0] e;
        e = {{MW{1'b0}}, v};
        return e[MW-1:0];
    endfunction

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign type_ext  = nfa_chk_pkg::FIELD_W'(ev_type);
    assign msg_ext   = nfa_chk_pkg::FIELD_W'(ev_message);
    assign org_ext   = nfa_chk_pkg::FIELD_W'(ev_origin);
    assign in_key    = {type_ext[KEY_BITS-1:0], msg_ext[KEY_BITS-1:0], org_ext[KEY_BITS-1:0]};
    assign mask_ext  = {{MAX_ROWS{1'b0}}, row_mask};
    assign mask_rows = mask_ext[MAX_ROWS-1:0];

    // Clamp the counts into the range the storage supports
    always_comb
    begin
        if (row_count_reg == 6'd0)
            rows_used = CW'(1);
        else if (CW'(row_count_reg) > CW'(MAX_ROWS))
            rows_used = CW'(MAX_ROWS);
        else
            rows_used = CW'(row_count_reg);

        if (col_count_reg == 5'd0)
            cols_used = CW'(1);
        else if (CW'(col_count_reg) > CW'(MAX_COLS))
            cols_used = CW'(MAX_COLS);
        else
            cols_used = CW'(col_count_reg);
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ROWS; i++)
            used_mask[i] = CW'(i) < rows_used;
    end

    always_comb
    begin
        for (int j = 0; j < MAX_COLS; j++)
            hit_now[j] = (CW'(j) < cols_used) && key_valid_reg[j] &&
                         (col_key_reg[j] == key_reg);
    end

    // State after a load or restore
    always_comb
    begin
        load_active = active_reg;
        load_end    = end_reg;
        unique case (opcode)
            nfa_chk_pkg::OP_LOAD_END: load_end    = mask_rows;
            nfa_chk_pkg::OP_RESTORE:  load_active = mask_rows;
            default:                  ;
        endcase
    end

    // Fold one row's matching cells
    always_comb
    begin
        logic [MAX_ROWS-1:0] t;
        row_reached = '0;
        row_moved   = 1'b0;
        row_empty   = 1'b0;
        for (int j = 0; j < MAX_COLS; j++)
        begin
            t = rd_data_reg[j] & used_mask;
            if (hit_reg[j])
            begin
                if (t == '0)
                    row_empty = 1'b1;
                else
                begin
                    row_reached = row_reached | t;
                    row_moved   = 1'b1;
                end
            end
        end
        row_act = active_reg[pend_row_reg];
    end

    assign rd_en    = (state_reg == ST_SCAN) && (rd_row_reg < rows_used);
    assign scan_end = (state_reg == ST_SCAN) && !rd_en && !pend_reg;

    always_comb
    begin
        if (mode_reg)
            fin_active = reached_reg | MAX_ROWS'(1);
        else
            fin_active = (reached_reg | kept_reg) & used_mask;
        fin_ematch = mode_reg && ((reached_reg & end_reg & used_mask) != '0);
        fin_viol   = !mode_reg && viol_reg;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            row_count_reg <= nfa_chk_pkg::ROW_COUNT_RST;
            col_count_reg <= nfa_chk_pkg::COL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                nfa_chk_pkg::CFG_MODE:      mode_reg      <= cfg_data[0];
                nfa_chk_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data;
                nfa_chk_pkg::CFG_COL_COUNT: col_count_reg <= cfg_data[4:0];
                default:                    ;
            endcase
        end
    end

    // Column keys
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == nfa_chk_pkg::OP_LOAD_KEY) && (CW'(col_index) < CW'(MAX_COLS)))
            col_key_reg[CIW'(col_index)] <= in_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_valid_reg <= '0;
        else if (accept && (opcode == nfa_chk_pkg::OP_LOAD_KEY) &&
                 (CW'(col_index) < CW'(MAX_COLS)))
            key_valid_reg[CIW'(col_index)] <= 1'b1;
    end

    // Cell memory: one cell written, one whole row read per cycle
    always_ff @(posedge clk)
    begin
        if (accept && (opcode == nfa_chk_pkg::OP_LOAD_CELL) &&
            (CW'(row_index) < CW'(MAX_ROWS)) && (CW'(col_index) < CW'(MAX_COLS)))
            cell_mem[RIW'(row_index)][CIW'(col_index)] <= mask_rows;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= cell_mem[rd_row_reg[RIW-1:0]];
    end

    // Sequencer, automaton state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= MAX_ROWS'(1);
            end_reg       <= '0;
            done          <= 1'b0;
            in_scope      <= 1'b0;
            violated      <= 1'b0;
            error_matched <= 1'b0;
            holds         <= 1'b0;
            active_set    <= '0;
            key_reg       <= '0;
            hit_reg       <= '0;
            reached_reg   <= '0;
            kept_reg      <= '0;
            viol_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            rd_row_reg    <= '0;
            pend_row_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (opcode == nfa_chk_pkg::OP_EVENT)
                        begin
                            key_reg   <= in_key;
                            state_reg <= ST_MATCH;
                        end
                        else
                        begin
                            active_reg    <= load_active;
                            end_reg       <= load_end;
                            done          <= 1'b1;
                            in_scope      <= 1'b0;
                            violated      <= 1'b0;
                            error_matched <= 1'b0;
                            holds         <= (load_active & load_end & used_mask) != '0;
                            active_set    <= to_port(load_active);
                        end
                    end
                end
                ST_MATCH:
                begin
                    hit_reg     <= hit_now;
                    reached_reg <= '0;
                    kept_reg    <= '0;
                    viol_reg    <= 1'b0;
                    rd_row_reg  <= '0;
                    pend_reg    <= 1'b0;
                    if (hit_now == '0)
                    begin
                        // Out of scope: report and change nothing
                        done          <= 1'b1;
                        in_scope      <= 1'b0;
                        violated      <= 1'b0;
                        error_matched <= 1'b0;
                        holds         <= (active_reg & end_reg & used_mask) != '0;
                        active_set    <= to_port(active_reg);
                        state_reg     <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    pend_reg <= rd_en;
                    if (rd_en)
                    begin
                        pend_row_reg <= rd_row_reg[RIW-1:0];
                        rd_row_reg   <= rd_row_reg + CW'(1);
                    end
                    if (pend_reg && row_act)
                    begin
                        reached_reg <= reached_reg | row_reached;
                        if (row_empty)
                            viol_reg <= 1'b1;
                        if (!row_moved)
                            kept_reg[pend_row_reg] <= 1'b1;
                    end
                    if (scan_end)
                    begin
                        active_reg    <= fin_active;
                        done          <= 1'b1;
                        in_scope      <= 1'b1;
                        violated      <= fin_viol;
                        error_matched <= fin_ematch;
                        holds         <= (fin_active & end_reg & used_mask) != '0;
                        active_set    <= to_port(fin_active);
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The two mode flags never appear together
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(violated && error_matched))
    else $error("violated and error_matched both set");

    // An out-of-scope result carries no flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_scope) |-> (!violated && !error_matched))
    else $error("flags set on out-of-scope result");

    // Key compare either ends the event or starts the row scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MATCH) |=> ((done && state_reg == ST_IDLE) || state_reg == ST_SCAN))
    else $error("bad exit from key compare");

    // Row data is only consumed during the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
    else $error("pending row outside scan");

    // Error mode restarts row zero after every in-scope event
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_scope && mode_reg) |-> active_set[0])
    else $error("row zero not restarted in error mode");
`endif

endmodule

// ===== dv/tb_nfa_result_checker.sv =====
// Checker for the automaton event checker: tracks config, predicts each result, compares.
module tb_nfa_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  opcode,
    input  logic [7:0]  ev_type,
    input  logic [7:0]  ev_message,
    input  logic [7:0]  ev_origin,
    input  logic [4:0]  row_index,
    input  logic [3:0]  col_index,
    input  logic [31:0] row_mask,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        done,
    input  logic        in_scope,
    input  logic        violated,
    input  logic        error_matched,
    input  logic        holds,
    input  logic [31:0] active_set,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        in_scope;
        logic        violated;
        logic        error_matched;
        logic        holds;
        logic [31:0] active_set;
    } nfa_result_t;

    logic        mode_q;
    logic [5:0]  rows_q;
    logic [4:0]  cols_q;
    logic [31:0] act_rows;
    logic [31:0] end_mask;
    logic [23:0] col_key [16];
    logic [15:0] key_ok;
    logic [31:0] cell_tgt [32][16];

    nfa_result_t expected_reports[$];
    nfa_result_t want;
    int          mism;

    // Apply one command to the shadow automaton and return the report it produces.
    function automatic nfa_result_t step_automaton(input logic [2:0] op,
                                                   input logic [23:0] key,
                                                   input logic [4:0] r,
                                                   input logic [3:0] c,
                                                   input logic [31:0] mask);
        nfa_result_t res;
        int          nr;
        int          nc;
        logic [31:0] used;
        logic [15:0] hit;
        logic        scope;
        logic        viol;
        logic        ematch;
        logic [31:0] reached;
        logic [31:0] kept;
        logic [31:0] tgt;
        logic        moved;
        logic        empty;
        nr = int'(rows_q);
        if (nr < 1) nr = 1;
        if (nr > 32) nr = 32;
        nc = int'(cols_q);
        if (nc < 1) nc = 1;
        if (nc > 16) nc = 16;
        used = (nr == 32) ? 32'hFFFF_FFFF : ((32'd1 << nr) - 32'd1);
        scope = 1'b0;
        viol = 1'b0;
        ematch = 1'b0;
        hit = '0;
        case (op)
            nfa_chk_pkg::OP_EVENT:
            begin
                for (int j = 0; j < nc; j++)
                begin
                    hit[j] = key_ok[j] && (col_key[j] == key);
                    if (hit[j]) scope = 1'b1;
                end
                if (scope)
                begin
                    reached = '0;
                    kept = '0;
                    for (int i = 0; i < nr; i++)
                    begin
                        if (act_rows[i])
                        begin
                            moved = 1'b0;
                            empty = 1'b0;
                            for (int j = 0; j < nc; j++)
                            begin
                                if (hit[j])
                                begin
                                    tgt = cell_tgt[i][j] & used;
                                    if (tgt == '0) empty = 1'b1;
                                    else
                                    begin
                                        reached = reached | tgt;
                                        moved = 1'b1;
                                    end
                                end
                            end
                            if (!mode_q)
                            begin
                                if (empty) viol = 1'b1;
                                if (!moved) kept[i] = 1'b1;
                            end
                        end
                    end
                    if (!mode_q)
                        act_rows = (reached | kept) & used;
                    else
                    begin
                        if ((reached & end_mask & used) != '0) ematch = 1'b1;
                        act_rows = (reached & used) | 32'd1;
                    end
                end
            end
            nfa_chk_pkg::OP_LOAD_KEY:
            begin
                col_key[c] = key;
                key_ok[c] = 1'b1;
            end
            nfa_chk_pkg::OP_LOAD_CELL: cell_tgt[r][c] = mask;
            nfa_chk_pkg::OP_LOAD_END:  end_mask = mask;
            nfa_chk_pkg::OP_RESTORE:   act_rows = mask;
            default: ;
        endcase
        res.in_scope = scope;
        res.violated = viol;
        res.error_matched = ematch;
        res.holds = ((act_rows & end_mask & used) != '0);
        res.active_set = act_rows;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q = 1'b0;
            rows_q = nfa_chk_pkg::ROW_COUNT_RST;
            cols_q = nfa_chk_pkg::COL_COUNT_RST;
            act_rows = 32'd1;
            end_mask = '0;
            key_ok = '0;
            expected_reports.delete();
            mism = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare before pushing, so a stray strobe never pairs with this cycle's transfer
            if (done)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result strobe with no transfer outstanding");
                    mism++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (in_scope !== want.in_scope)
                    begin
                        $error("in_scope expected %0d actual %0d", want.in_scope, in_scope);
                        mism++;
                    end
                    if (violated !== want.violated)
                    begin
                        $error("violated expected %0d actual %0d", want.violated, violated);
                        mism++;
                    end
                    if (error_matched !== want.error_matched)
                    begin
                        $error("error_matched expected %0d actual %0d",
                               want.error_matched, error_matched);
                        mism++;
                    end
                    if (holds !== want.holds)
                    begin
                        $error("holds expected %0d actual %0d", want.holds, holds);
                        mism++;
                    end
                    if (active_set !== want.active_set)
                    begin
                        $error("active_set expected %h actual %h", want.active_set, active_set);
                        mism++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nfa_chk_pkg::CFG_MODE:      mode_q = cfg_data[0];
                    nfa_chk_pkg::CFG_ROW_COUNT: rows_q = cfg_data;
                    nfa_chk_pkg::CFG_COL_COUNT: cols_q = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_reports.push_back(step_automaton(opcode,
                    {ev_type, ev_message, ev_origin}, row_index, col_index, row_mask));
            fail_count <= mism;
            outstanding <= expected_reports.size();
        end
    end

endmodule

// ===== dv/tb_table_driven_nfa_event_checker_core.sv =====
// Testbench top for the automaton event checker: clock, reset, stimulus and verdict.
module tb_table_driven_nfa_event_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 76;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  opcode = '0;
    logic [7:0]  ev_type = '0;
    logic [7:0]  ev_message = '0;
    logic [7:0]  ev_origin = '0;
    logic [4:0]  row_index = '0;
    logic [3:0]  col_index = '0;
    logic [31:0] row_mask = '0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [5:0]  cfg_data = '0;
    wire         busy;
    wire         cfg_ready;
    wire         done;
    wire         in_scope;
    wire         violated;
    wire         error_matched;
    wire         holds;
    wire  [31:0] active_set;

    int          fail_count;
    int          outstanding;
    int          idle_pct = 0;
    int          stall_cycles = 0;
    int          eff_rows = 32;
    int          eff_cols = 16;
    logic [23:0] key_shadow [16];
    logic [15:0] key_loaded = '0;

    table_driven_nfa_event_checker_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .ev_type(ev_type), .ev_message(ev_message), .ev_origin(ev_origin),
        .row_index(row_index), .col_index(col_index), .row_mask(row_mask),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .in_scope(in_scope), .violated(violated),
        .error_matched(error_matched), .holds(holds), .active_set(active_set)
    );

    tb_nfa_result_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .ev_type(ev_type), .ev_message(ev_message), .ev_origin(ev_origin),
        .row_index(row_index), .col_index(col_index), .row_mask(row_mask),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .in_scope(in_scope), .violated(violated),
        .error_matched(error_matched), .holds(holds), .active_set(active_set),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always #6 clk = ~clk;

    // End the run if nothing transfers for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || (cfg_valid && cfg_ready) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic int clamp_count(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // A few target rows inside the rows in use
    function automatic logic [31:0] sparse_rows();
        logic [31:0] m;
        int          k;
        m = '0;
        k = $urandom_range(3, 1);
        for (int i = 0; i < k; i++)
            m = m | (32'd1 << $urandom_range(eff_rows - 1));
        return m;
    endfunction

    function automatic logic [31:0] cell_targets_pick();
        logic [31:0] used;
        used = (eff_rows == 32) ? 32'hFFFF_FFFF : ((32'd1 << eff_rows) - 32'd1);
        case ($urandom_range(9))
            0: return '0;
            1: return $urandom;
            2: return $urandom & ~used;
            default: return sparse_rows();
        endcase
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [23:0] key,
                            input logic [4:0] r, input logic [3:0] c,
                            input logic [31:0] mask);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        ev_type <= key[23:16];
        ev_message <= key[15:8];
        ev_origin <= key[7:0];
        row_index <= r;
        col_index <= c;
        row_mask <= mask;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic load_key(input logic [3:0] c, input logic [23:0] key);
        key_shadow[c] = key;
        key_loaded[c] = 1'b1;
        send_cmd(nfa_chk_pkg::OP_LOAD_KEY, key, 5'($urandom), c, $urandom);
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [5:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        if (idx == nfa_chk_pkg::CFG_ROW_COUNT)
            eff_rows = clamp_count(int'(val), 32);
        else if (idx == nfa_chk_pkg::CFG_COL_COUNT)
            eff_cols = clamp_count(int'(val[4:0]), 16);
    endtask

    task automatic set_config(input int md, input int rows, input int cols);
        wait_idle();
        cfg_write(nfa_chk_pkg::CFG_MODE, 6'(md), 1'b0);
        cfg_write(nfa_chk_pkg::CFG_ROW_COUNT, 6'(rows), 1'b0);
        cfg_write(nfa_chk_pkg::CFG_COL_COUNT, 6'(cols), 1'b1);
    endtask

    task automatic random_item();
        int          p;
        int          j;
        logic [23:0] key;
        logic [4:0]  r;
        logic [3:0]  c;
        logic [31:0] m;
        p = $urandom_range(99);
        if (p < 52)
        begin
            j = $urandom_range(eff_cols - 1);
            if ($urandom_range(3) != 0 && key_loaded[j])
                key = key_shadow[j];
            else if ($urandom_range(1) != 0 && key_loaded[j])
                key = key_shadow[j] ^ (24'd1 << $urandom_range(23));
            else
                key = 24'($urandom);
            send_cmd(nfa_chk_pkg::OP_EVENT, key, 5'($urandom), 4'($urandom), $urandom);
        end
        else if (p < 72)
        begin
            r = ($urandom_range(3) != 0) ? 5'($urandom_range(eff_rows - 1)) : 5'($urandom);
            c = ($urandom_range(3) != 0) ? 4'($urandom_range(eff_cols - 1)) : 4'($urandom);
            send_cmd(nfa_chk_pkg::OP_LOAD_CELL, 24'($urandom), r, c, cell_targets_pick());
        end
        else if (p < 80)
        begin
            c = ($urandom_range(3) != 0) ? 4'($urandom_range(eff_cols - 1)) : 4'($urandom);
            j = $urandom_range(15);
            // Copy another column's key now and then so several columns hit at once
            if ($urandom_range(1) != 0 && key_loaded[j])
                key = key_shadow[j];
            else
                key = 24'($urandom);
            load_key(c, key);
        end
        else if (p < 85)
        begin
            m = ($urandom_range(3) == 0) ? 32'($urandom) : sparse_rows();
            send_cmd(nfa_chk_pkg::OP_LOAD_END, 24'($urandom), 5'($urandom), 4'($urandom), m);
        end
        else if (p < 92)
        begin
            case ($urandom_range(3))
                0: m = '0;
                1: m = $urandom;
                default: m = sparse_rows();
            endcase
            send_cmd(nfa_chk_pkg::OP_RESTORE, 24'($urandom), 5'($urandom), 4'($urandom), m);
        end
        else if (p < 97)
            send_cmd(3'($urandom_range(7, 5)), 24'($urandom), 5'($urandom), 4'($urandom),
                     $urandom);
        else
        begin
            wait_idle();
            send_cmd(nfa_chk_pkg::OP_EVENT, key_shadow[0], 5'($urandom), 4'($urandom),
                     $urandom);
        end
    endtask

    initial
    begin
        int ph_mode [PHASES];
        int ph_rows [PHASES];
        int ph_cols [PHASES];
        ph_mode = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
        ph_rows = '{32, 32, 4, 5, 1, 2, 17, 0, 63, 9};
        ph_cols = '{16, 16, 3, 4, 1, 16, 9, 0, 31, 2};
        for (int i = 0; i < 16; i++)
            key_shadow[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No key loaded yet: nothing is in scope
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'h123456, 5'd0, 4'd0, 32'h0);
        send_cmd(3'd5, 24'hFFFFFF, 5'd31, 4'd15, 32'hFFFF_FFFF);
        send_cmd(3'd6, 24'($urandom), 5'($urandom), 4'($urandom), $urandom);
        send_cmd(3'd7, 24'h000000, 5'd0, 4'd0, 32'h0);

        // Fill the whole cell table before any event can read it
        for (int r = 0; r < 32; r++)
            for (int c = 0; c < 16; c++)
                send_cmd(nfa_chk_pkg::OP_LOAD_CELL, 24'($urandom), 5'(r), 4'(c),
                         cell_targets_pick());

        load_key(4'd0, 24'hFFFFFF);
        load_key(4'd15, 24'h000000);
        send_cmd(nfa_chk_pkg::OP_LOAD_END, 24'h0, 5'd0, 4'd0, 32'h8000_0001);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'hFFFFFF, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'h000000, 5'd31, 4'd15, 32'hFFFF_FFFF);
        // Empty cell on an active row: violation, row stays
        send_cmd(nfa_chk_pkg::OP_LOAD_CELL, 24'h0, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_RESTORE, 24'h0, 5'd0, 4'd0, 32'h0000_0001);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'hFFFFFF, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_RESTORE, 24'h0, 5'd0, 4'd0, 32'hFFFF_FFFF);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'h000000, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_RESTORE, 24'h0, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'hFFFFFF, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_LOAD_CELL, 24'h0, 5'd31, 4'd15, 32'hFFFF_FFFF);

        // Error search: restart row, end rows reached
        set_config(1, 32, 16);
        send_cmd(nfa_chk_pkg::OP_RESTORE, 24'h0, 5'd0, 4'd0, 32'h0000_0001);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'hFFFFFF, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'h000000, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'h000000, 5'd0, 4'd0, 32'h0);

        // Counts below and above range saturate; index three is ignored
        wait_idle();
        cfg_write(nfa_chk_pkg::CFG_ROW_COUNT, 6'd0, 1'b0);
        cfg_write(nfa_chk_pkg::CFG_COL_COUNT, 6'd0, 1'b0);
        cfg_write(2'd3, 6'h3F, 1'b1);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'hFFFFFF, 5'd0, 4'd0, 32'h0);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'h000000, 5'd0, 4'd0, 32'h0);
        set_config(0, 63, 31);
        send_cmd(nfa_chk_pkg::OP_EVENT, 24'h000000, 5'd0, 4'd0, 32'h0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph >= 8)
                set_config($urandom_range(1), $urandom_range(63), $urandom_range(31));
            else
                set_config(ph_mode[ph], ph_rows[ph], ph_cols[ph]);
            idle_pct = (ph < 4) ? 21 : ((ph < 7) ? 50 : 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_item();
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
design/nfa_chk_pkg.sv
design/table_driven_nfa_event_checker_core.sv
dv/tb_nfa_result_checker.sv
dv/tb_table_driven_nfa_event_checker_core.sv
